[rtl/tios_pkg.sv]
// Package for the time-index offset search block.
// Holds the controller state type, request codes and the command and status bundles.
// Used by the controller, the datapath and the top level.
package tios_pkg;

  // Request codes carried in req_type.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // Table times are stored already scaled from milliseconds to microseconds.
  localparam int UsPerMs     = 1000;
  localparam int TimeW       = 32;
  localparam int ScaledTimeW = 42;
  localparam int OffsetW     = 63;
  localparam int IndexW      = 12;
  localparam int CountW      = 13;
  localparam int PtsW        = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH
  } tios_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;  // write one table entry from the input beat
    logic start;    // latch the query and issue the first probe
    logic step;     // narrow the interval and issue the next probe
    logic fetch;    // read the offset of the chosen entry
    logic emit;     // load the output register
  } tios_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;  // interval holds at most one entry
    logic out_free;     // output register can take a beat this cycle
  } tios_sts_t;

endpackage

[rtl/tios_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// Read data holds its value in cycles without a read.
// No dependencies.
module tios_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tios_ctrl.sv]
// Controller state machine for the time-index offset search.
// Sequences loads, the binary-search probes, the offset fetch and the result beat.
// Depends on tios_pkg.
module tios_ctrl
  import tios_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      req_type_i,
  output logic      in_stall_o,
  input  tios_sts_t sts_i,
  output tios_cmd_t cmd_o
);

  tios_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (req_type_i == ReqQuery)) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.search_done) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output logic: input beats are taken only in idle.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_wr = in_valid_i && (req_type_i == ReqLoad);
        cmd_o.start   = in_valid_i && (req_type_i == ReqQuery);
      end
      ST_SEARCH: begin
        cmd_o.step  = !sts_i.search_done;
        cmd_o.fetch = sts_i.search_done;
      end
      ST_FETCH: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/tios_dp.sv]
// Datapath for the time-index offset search: table memories, search interval,
// output register and the entry count register.
// Depends on tios_pkg and tios_ram.
module tios_dp
  import tios_pkg::*;
#(
  parameter int TableDepth = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tios_cmd_t           cmd_i,
  output tios_sts_t           sts_o,
  input  logic                entry_count_we_i,
  input  logic [CountW-1:0]   entry_count_i,
  input  logic [IndexW-1:0]   load_index_i,
  input  logic [TimeW-1:0]    load_time_ms_i,
  input  logic [OffsetW-1:0]  load_byte_offset_i,
  input  logic signed [PtsW-1:0] query_pts_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OffsetW-1:0]  byte_position_o,
  output logic [IndexW-1:0]   chosen_index_o
);

  localparam int AW   = $clog2(TableDepth);
  localparam int HW   = $clog2(TableDepth + 1);
  localparam int CmpW = (HW > CountW) ? HW : CountW;
  localparam int LdW  = (HW > IndexW) ? HW : IndexW;

  logic [CountW-1:0]      entry_count_q;
  logic [HW-1:0]          lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]          mid_q, mid_d;
  logic [AW-1:0]          idx_q;
  logic signed [PtsW-1:0] pts_q;
  logic                   out_valid_q;
  logic [OffsetW-1:0]     byte_position_q;
  logic [IndexW-1:0]      chosen_index_q;

  logic [CmpW-1:0]        cnt_sat;
  logic [HW-1:0]          hi_init;
  logic signed [PtsW-1:0] pts_adj;
  logic                   load_ok;
  logic [ScaledTimeW-1:0] scaled_wdata;
  logic [ScaledTimeW-1:0] scaled_rdata;
  logic [OffsetW-1:0]     offset_rdata;
  logic                   probe_gt;
  logic [HW:0]            mid_sum;
  logic [AW-1:0]          times_raddr;
  logic [AW-1:0]          fetch_idx;
  logic                   search_done;
  logic                   out_free;

  // Entry count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= CountW'(1);
    end else if (entry_count_we_i) begin
      entry_count_q <= entry_count_i;
    end
  end

  // The search bound saturates at the table depth.
  assign cnt_sat = (CmpW'(entry_count_q) > CmpW'(TableDepth)) ? CmpW'(TableDepth)
                                                               : CmpW'(entry_count_q);
  assign hi_init = HW'(cnt_sat);

  // Truncating the timestamp to milliseconds and comparing with a table time
  // is the same as comparing the time scaled by 1000 with the timestamp. A
  // timestamp between -999 and -1 truncates to zero, and any lower one is
  // below every table time.
  always_comb begin
    if (!query_pts_i[PtsW-1]) begin
      pts_adj = query_pts_i;
    end else if (query_pts_i <= -PtsW'(UsPerMs)) begin
      pts_adj = -PtsW'(1);
    end else begin
      pts_adj = '0;
    end
  end

  // Loads beyond the table are dropped.
  assign load_ok      = LdW'(load_index_i) < LdW'(TableDepth);
  assign scaled_wdata = ScaledTimeW'(load_time_ms_i) * ScaledTimeW'(UsPerMs);

  // Probe result: entry time is above the query time.
  assign probe_gt = $signed({{(PtsW - ScaledTimeW){1'b0}}, scaled_rdata}) > pts_q;

  // Interval update and next midpoint.
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = hi_init;
    end else if (cmd_i.step) begin
      if (probe_gt) begin
        hi_d = HW'(mid_q);
      end else begin
        lo_d = HW'(mid_q);
      end
    end
  end

  assign mid_sum     = {1'b0, lo_d} + {1'b0, hi_d};
  assign mid_d       = AW'(mid_sum[HW:1]);
  assign times_raddr = mid_d;

  assign search_done = (hi_q - lo_q) <= HW'(1);
  assign fetch_idx   = (lo_q != '0) ? AW'(lo_q - HW'(1)) : '0;

  // Search registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      mid_q <= '0;
    end else if (cmd_i.start || cmd_i.step) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      mid_q <= mid_d;
    end
  end

  // Query timestamp and chosen index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pts_q <= pts_adj;
    end
    if (cmd_i.fetch) begin
      idx_q <= fetch_idx;
    end
  end

  // Table memories.
  tios_ram #(
    .Width(ScaledTimeW),
    .Depth(TableDepth)
  ) u_times_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr && load_ok),
    .waddr_i (AW'(load_index_i)),
    .wdata_i (scaled_wdata),
    .re_i    (cmd_i.start || cmd_i.step),
    .raddr_i (times_raddr),
    .rdata_o (scaled_rdata)
  );

  tios_ram #(
    .Width(OffsetW),
    .Depth(TableDepth)
  ) u_offsets_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr && load_ok),
    .waddr_i (AW'(load_index_i)),
    .wdata_i (load_byte_offset_i),
    .re_i    (cmd_i.fetch),
    .raddr_i (fetch_idx),
    .rdata_o (offset_rdata)
  );

  // Output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      byte_position_q <= offset_rdata;
      chosen_index_q  <= IndexW'(idx_q);
    end
  end

  assign sts_o.search_done = search_done;
  assign sts_o.out_free    = out_free;
  assign out_valid_o       = out_valid_q;
  assign byte_position_o   = byte_position_q;
  assign chosen_index_o    = chosen_index_q;

  // The interval never turns inside out.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hi_q >= lo_q)
    else $error("search interval end below its start");

  // Every probe strictly shrinks the interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (hi_q - lo_q) < $past(hi_q - lo_q))
    else $error("search step did not narrow the interval");

  // A result is never loaded over a beat that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.emit |-> out_free)
    else $error("result overwrote a pending output beat");

endmodule

[rtl/time_index_offset_search.sv]
// Time-index offset search. A load beat (req_type 0) writes one table entry; a query
// beat (req_type 1) binary-searches the first entry_count entries for the last entry
// whose time does not exceed the timestamp in milliseconds, steps back one entry when
// that index is above zero, and returns one beat with the entry's byte offset and index.
// While a query is in progress the block stalls new input beats, also while the output
// stalls with an earlier result still waiting. The search is a probe loop: each probe is
// one registered read of the time memory whose data picks the next probe address. Times
// are stored pre-multiplied by 1000, so queries need no divider. Entries must be loaded
// before a query reaches them; the table has no reset.
module time_index_offset_search
  import tios_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   entry_count_we_i,
  input  logic [CountW-1:0]      entry_count_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [IndexW-1:0]      load_index_i,
  input  logic [TimeW-1:0]       load_time_ms_i,
  input  logic [OffsetW-1:0]     load_byte_offset_i,
  input  logic signed [PtsW-1:0] query_pts_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OffsetW-1:0]     byte_position_o,
  output logic [IndexW-1:0]      chosen_index_o
);

  tios_cmd_t cmd;
  tios_sts_t sts;

  // Sequencer.
  tios_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, search interval and output register.
  tios_dp #(
    .TableDepth(TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .entry_count_we_i   (entry_count_we_i),
    .entry_count_i      (entry_count_i),
    .load_index_i       (load_index_i),
    .load_time_ms_i     (load_time_ms_i),
    .load_byte_offset_i (load_byte_offset_i),
    .query_pts_i        (query_pts_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .byte_position_o    (byte_position_o),
    .chosen_index_o     (chosen_index_o)
  );

endmodule
